// ----- hw/rtl/rvd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rvd_pkg;

    localparam int ELEM_W    = 16;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DIST_W    = 24;
    localparam int FRAC_W    = 8;
    localparam int ROOT_IN_W = 2 * DIST_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SQRT = 4'b0100,
        S_FIN  = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rms_vector_distance_unit.sv -----
// result path: the last word's square is registered, then its vector's sum and count
// go into the queue; the back runs the bit-serial divide, then the bit-serial root
// throughput: the front takes one word per cycle unless stalled; the back starts a
// vector only when done; a two-entry queue lets the front run ahead by two vectors
// reset: rst_n asynchronous, active low; clears the sum, count, queue and result valid
`timescale 1ns / 1ps
`default_nettype none

module rms_vector_distance_unit
    import rvd_pkg::*;
#(
    parameter int MAX_LEN = 4096,
    localparam int CNT_W  = $clog2(MAX_LEN + 1),
    localparam int SUM_W  = SQ_W + $clog2(MAX_LEN)
) (
    input  wire  logic                     clk,
    input  wire  logic                     rst_n,
    input  wire  logic                     in_valid,
    output logic                           in_stall,
    input  wire  logic signed [ELEM_W-1:0] elem_a,
    input  wire  logic signed [ELEM_W-1:0] elem_b,
    input  wire  logic                     last_elem,
    output logic                           out_valid,
    input  wire  logic                     out_stall,
    output logic [DIST_W-1:0]              distance,
    output logic [CNT_W-1:0]               pair_count,
    output logic                           length_overflow
);

    localparam int Q_W = SUM_W + CNT_W + 1;

    logic             q_full;
    logic             q_push;
    logic [SUM_W-1:0] f_sum;
    logic [CNT_W-1:0] f_cnt;
    logic             f_ovf;
    logic             q_not_empty;
    logic             q_pop;
    logic [Q_W-1:0]   q_rd_data;

    rvd_front #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last_elem (last_elem),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_sum     (f_sum),
        .q_cnt     (f_cnt),
        .q_ovf     (f_ovf)
    );

    rvd_queue #(
        .W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ovf, f_cnt, f_sum}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rd_data)
    );

    rvd_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_not_empty),
        .q_pop           (q_pop),
        .q_sum           (q_rd_data[SUM_W-1:0]),
        .q_cnt           (q_rd_data[SUM_W +: CNT_W]),
        .q_ovf           (q_rd_data[Q_W-1]),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .distance        (distance),
        .pair_count      (pair_count),
        .length_overflow (length_overflow)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rvd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rvd_front
    import rvd_pkg::*;
#(
    parameter int MAX_LEN = 4096,
    parameter int CNT_W   = 13,
    parameter int SUM_W   = 44
) (
    input  wire  logic                     clk,
    input  wire  logic                     rst_n,
    input  wire  logic                     in_valid,
    output logic                           in_stall,
    input  wire  logic signed [ELEM_W-1:0] elem_a,
    input  wire  logic signed [ELEM_W-1:0] elem_b,
    input  wire  logic                     last_elem,
    input  wire  logic                     q_full,
    output logic                           q_push,
    output logic [SUM_W-1:0]               q_sum,
    output logic [CNT_W-1:0]               q_cnt,
    output logic                           q_ovf
);

    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_last_reg;
    logic [SQ_W-1:0]         s1_sq_reg;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;
    logic                    s1_hold;
    logic                    in_fire;
    logic                    s1_fire;
    logic                    sat;
    logic signed [ELEM_W:0]  diff;
    logic [ELEM_W:0]         diff_abs;
    logic [MAG_W-1:0]        mag;
    logic [SUM_W-1:0]        sum_upd;
    logic [CNT_W-1:0]        cnt_upd;
    logic                    ovf_upd;

    assign s1_hold  = s1_valid_reg && s1_last_reg && q_full;
    assign in_stall = s1_hold;
    assign in_fire  = in_valid && !s1_hold;
    assign s1_fire  = s1_valid_reg && !s1_hold;

    // squared difference stage
    assign diff     = {elem_a[ELEM_W-1], elem_a} - {elem_b[ELEM_W-1], elem_b};
    assign diff_abs = diff[ELEM_W] ? (~diff + 1'b1) : diff;
    assign mag      = diff_abs[MAG_W-1:0];

    // accumulate stage, count saturates at the length limit
    assign sat     = (cnt_reg == CNT_W'(MAX_LEN));
    assign sum_upd = sat ? sum_reg : sum_reg + SUM_W'(s1_sq_reg);
    assign cnt_upd = sat ? cnt_reg : cnt_reg + 1'b1;
    assign ovf_upd = ovf_reg | sat;

    assign q_push = s1_fire && s1_last_reg;
    assign q_sum  = sum_upd;
    assign q_cnt  = cnt_upd;
    assign q_ovf  = ovf_upd;

    always_comb
    begin
        s1_valid_next = s1_hold ? s1_valid_reg : in_fire;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                sum_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_upd;
                cnt_next = cnt_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_hold)
        begin
            s1_sq_reg   <= SQ_W'(mag) * SQ_W'(mag);
            s1_last_reg <= last_elem;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rvd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rvd_queue #(
    parameter int W = 58
) (
    input  wire  logic         clk,
    input  wire  logic         rst_n,
    input  wire  logic         push,
    input  wire  logic [W-1:0] push_data,
    output logic               full,
    input  wire  logic         pop,
    output logic               not_empty,
    output logic [W-1:0]       pop_data
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rvd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rvd_back
    import rvd_pkg::*;
#(
    parameter int CNT_W = 13,
    parameter int SUM_W = 44
) (
    input  wire  logic             clk,
    input  wire  logic             rst_n,
    input  wire  logic             q_valid,
    output logic                   q_pop,
    input  wire  logic [SUM_W-1:0] q_sum,
    input  wire  logic [CNT_W-1:0] q_cnt,
    input  wire  logic             q_ovf,
    output logic                   out_valid,
    input  wire  logic             out_stall,
    output logic [DIST_W-1:0]      distance,
    output logic [CNT_W-1:0]       pair_count,
    output logic                   length_overflow
);

    localparam int DIV_W  = SUM_W + 2 * FRAC_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int REM_W  = CNT_W + 1;
    localparam int SREM_W = DIST_W + 2;

    back_state_t              state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DIV_W-1:0]         div_reg, div_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         divisor_reg, divisor_next;
    logic                     ovf_reg, ovf_next;
    logic [ROOT_IN_W-1:0]     rad_reg, rad_next;
    logic [SREM_W-1:0]        srem_reg, srem_next;
    logic [DIST_W-1:0]        root_reg, root_next;
    logic [DIST_W-1:0]        dist_out_reg;
    logic [CNT_W-1:0]         cnt_out_reg;
    logic                     ovf_out_reg;
    logic                     out_load;

    logic [REM_W:0]           rem_sh;
    logic                     div_ge;
    logic [REM_W:0]           rem_sub;
    logic [SREM_W+1:0]        srem_sh;
    logic [SREM_W+1:0]        trial;
    logic                     sq_ge;
    logic [SREM_W+1:0]        srem_sub;

    // restoring divide, one quotient bit per cycle
    assign rem_sh  = {rem_reg, div_reg[DIV_W-1]};
    assign div_ge  = (rem_sh >= (REM_W+1)'(divisor_reg));
    assign rem_sub = rem_sh - (REM_W+1)'(divisor_reg);

    // digit-by-digit square root, one root bit per cycle
    assign srem_sh  = {srem_reg, rad_reg[ROOT_IN_W-1 -: 2]};
    assign trial    = (SREM_W+2)'({root_reg, 2'b01});
    assign sq_ge    = (srem_sh >= trial);
    assign srem_sub = srem_sh - trial;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    assign out_valid       = out_valid_reg;
    assign distance        = dist_out_reg;
    assign pair_count      = cnt_out_reg;
    assign length_overflow = ovf_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        ovf_next       = ovf_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            out_valid_next = out_load;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    div_next     = {q_sum, {(2 * FRAC_W){1'b0}}};
                    rem_next     = '0;
                    divisor_next = q_cnt;
                    ovf_next     = q_ovf;
                    step_next    = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                div_next  = {div_reg[DIV_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    rad_next   = div_next[ROOT_IN_W-1:0];
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                srem_next = sq_ge ? srem_sub[SREM_W-1:0] : srem_sh[SREM_W-1:0];
                rad_next  = {rad_reg[ROOT_IN_W-3:0], 2'b00};
                root_next = {root_reg[DIST_W-2:0], sq_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIST_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        ovf_reg     <= ovf_next;
        rad_reg     <= rad_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        if (out_load)
        begin
            dist_out_reg <= root_reg;
            cnt_out_reg  <= divisor_reg;
            ovf_out_reg  <= ovf_reg;
        end
    end

endmodule

`default_nettype wire
